// File: design/pbba_pkg.sv
// Shared types, constants and helpers for the power-of-two bucket block allocator.
// No dependencies; imported by every design module.
package pbba_pkg;

  localparam int NUM_BUCKETS       = 8;
  localparam int SMALLEST_CAPACITY = 8;
  localparam int HEADER_BYTES      = 6;
  localparam int HEAP_GRANULES     = 32768;

  localparam int ADDR_W = 16;
  localparam int BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int IDX_W  = $clog2(HEAP_GRANULES);
  localparam int STAT_W = 3;

  localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
  localparam logic [STAT_W-1:0] ST_TOO_BIG     = 3'd1;
  localparam logic [STAT_W-1:0] ST_OOM         = 3'd2;
  localparam logic [STAT_W-1:0] ST_DOUBLE_FREE = 3'd3;
  localparam logic [STAT_W-1:0] ST_NO_BLOCK    = 3'd4;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  function automatic logic [31:0] cap_of(input logic [31:0] b);
    cap_of = 32'(SMALLEST_CAPACITY) << b;
  endfunction

  function automatic logic [31:0] foot_of(input logic [31:0] b);
    logic [31:0] f;
    f = cap_of(b) + 32'(HEADER_BYTES);
    foot_of = f + {31'b0, f[0]};
  endfunction

  localparam int FOOT_W = $clog2(foot_of(32'(NUM_BUCKETS - 1)) + 1);
  localparam int SUM_W  = (FOOT_W > ADDR_W) ? FOOT_W + 2 : ADDR_W + 2;

  typedef struct packed {
    logic              exists;
    logic              in_use;
    logic [BKT_W-1:0]  bucket;
    logic              next_valid;
    logic [ADDR_W-1:0] next;
  } hdr_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] offset;
  } head_t;

  typedef struct packed {
    logic clr;
    logic latch;
    logic rd;
    logic eval_commit;
    logic wb_commit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic need_read;
    logic out_free;
  } sts_t;

endpackage

// File: design/pbba_ctrl.sv
// Request sequencer: header clearing pass, accept, evaluate, write back.
// Depends on pbba_pkg; drives pbba_dp through cmd_t and reads sts_t.
module pbba_ctrl
  import pbba_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EVAL  = 2'd2;
  localparam logic [1:0] S_WB    = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts.need_read) begin
          cmd.rd    = 1'b1;
          state_nxt = S_WB;
        end else if (sts.out_free) begin
          cmd.eval_commit = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_WB: begin
        if (sts.out_free) begin
          cmd.wb_commit = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

endmodule

// File: design/pbba_dp.sv
// Allocator datapath: request latch, bucket select, break pointer, list heads,
// block header memory and result register. Depends on pbba_pkg.
module pbba_dp
  import pbba_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [ADDR_W-1:0] heap_start,
  input  logic [ADDR_W-1:0] heap_limit,
  input  logic              in_req_type,
  input  logic [ADDR_W-1:0] in_req_size,
  input  logic [ADDR_W-1:0] in_block_addr,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ADDR_W-1:0] out_result_addr,
  output logic [STAT_W-1:0] out_status
);

  logic              req_type_r;
  logic [ADDR_W-1:0] req_size_r;
  logic [ADDR_W-1:0] block_addr_r;

  logic [ADDR_W-1:0] brk_r, brk_nxt;
  head_t             head_r   [NUM_BUCKETS];
  head_t             head_nxt [NUM_BUCKETS];
  logic [IDX_W-1:0]  clr_idx_r;

  hdr_t              hdr_mem [HEAP_GRANULES];
  hdr_t              rd_q;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa, mem_ra;
  hdr_t              mem_wd;

  logic              out_valid_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [STAT_W-1:0] out_status_r;
  logic              load_out;
  logic [ADDR_W-1:0] res_addr;
  logic [STAT_W-1:0] res_status;

  logic [NUM_BUCKETS-1:0] fits;
  logic [BKT_W-1:0]  bkt;
  logic              too_big;
  head_t             head_sel;
  logic [FOOT_W-1:0] foot;
  logic [SUM_W-1:0]  new_brk;
  logic [SUM_W-1:0]  brk_end;
  logic              oom;
  logic [ADDR_W-1:0] free_off;
  logic              free_ok;
  logic              is_alloc;

  // bucket select: smallest capacity that holds the size
  always_comb begin
    bkt = '0;
    for (int i = 0; i < NUM_BUCKETS; i++) begin
      fits[i] = 32'(req_size_r) <= cap_of(32'(i));
    end
    for (int i = NUM_BUCKETS - 1; i >= 0; i--) begin
      if (fits[i]) bkt = BKT_W'(i);
    end
  end

  assign is_alloc = (req_type_r == REQ_ALLOC);
  assign too_big  = !fits[NUM_BUCKETS-1];
  assign head_sel = head_r[bkt];
  assign foot     = FOOT_W'(foot_of(32'(bkt)));
  assign new_brk  = SUM_W'(brk_r) + SUM_W'(foot);
  assign brk_end  = SUM_W'(heap_start) + new_brk;
  assign oom      = (brk_end > SUM_W'(heap_limit)) ||
                    (32'(new_brk) > 32'(2 * HEAP_GRANULES));

  assign free_off = block_addr_r - ADDR_W'(HEADER_BYTES) - heap_start;
  assign free_ok  = (block_addr_r != '0) && !free_off[0] &&
                    (32'(free_off[ADDR_W-1:1]) < 32'(HEAP_GRANULES));

  assign mem_ra = is_alloc ? head_sel.offset[IDX_W:1] : free_off[IDX_W:1];

  assign sts.need_read = is_alloc ? (!too_big && head_sel.valid) : free_ok;
  assign sts.out_free  = !out_valid_r || out_ready;
  assign sts.clr_last  = (clr_idx_r == IDX_W'(HEAP_GRANULES - 1));

  always_comb begin
    mem_we     = 1'b0;
    mem_wa     = clr_idx_r;
    mem_wd     = '0;
    brk_nxt    = brk_r;
    head_nxt   = head_r;
    load_out   = 1'b0;
    res_addr   = '0;
    res_status = ST_OK;
    if (cmd.clr) begin
      mem_we = 1'b1;
    end
    if (cmd.eval_commit) begin
      load_out = 1'b1;
      if (is_alloc) begin
        if (too_big) begin
          res_status = ST_TOO_BIG;
        end else if (oom) begin
          res_status = ST_OOM;
        end else begin
          mem_we            = 1'b1;
          mem_wa            = brk_r[IDX_W:1];
          mem_wd.exists     = 1'b1;
          mem_wd.in_use     = 1'b1;
          mem_wd.bucket     = bkt;
          brk_nxt           = new_brk[ADDR_W-1:0];
          res_addr          = heap_start + brk_r + ADDR_W'(HEADER_BYTES);
        end
      end else if (block_addr_r != '0) begin
        res_status = ST_NO_BLOCK;
      end
    end
    if (cmd.wb_commit) begin
      load_out = 1'b1;
      if (is_alloc) begin
        mem_we        = 1'b1;
        mem_wa        = mem_ra;
        mem_wd.exists = rd_q.exists;
        mem_wd.in_use = 1'b1;
        mem_wd.bucket = rd_q.bucket;
        head_nxt[bkt] = '{valid: rd_q.next_valid, offset: rd_q.next};
        res_addr      = heap_start + head_sel.offset + ADDR_W'(HEADER_BYTES);
      end else if (!rd_q.exists) begin
        res_status = ST_NO_BLOCK;
      end else if (!rd_q.in_use) begin
        res_status = ST_DOUBLE_FREE;
      end else begin
        mem_we                = 1'b1;
        mem_wa                = mem_ra;
        mem_wd.exists         = 1'b1;
        mem_wd.in_use         = 1'b0;
        mem_wd.bucket         = rd_q.bucket;
        mem_wd.next_valid     = head_r[rd_q.bucket].valid;
        mem_wd.next           = head_r[rd_q.bucket].offset;
        head_nxt[rd_q.bucket] = '{valid: 1'b1, offset: free_off};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) hdr_mem[mem_wa] <= mem_wd;
    if (cmd.rd) rd_q <= hdr_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_type_r   <= in_req_type;
      req_size_r   <= in_req_size;
      block_addr_r <= in_block_addr;
    end
    if (load_out) begin
      out_addr_r   <= res_addr;
      out_status_r <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brk_r       <= '0;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        head_r[i].valid <= 1'b0;
      end
    end else begin
      brk_r <= brk_nxt;
      if (cmd.clr) clr_idx_r <= clr_idx_r + 1'b1;
      if (load_out)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        head_r[i] <= head_nxt[i];
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_addr = out_addr_r;
  assign out_status      = out_status_r;

`ifndef SYNTHESIS
  a_brk_monotonic: assert property (@(posedge clk)
    rst_n && $past(rst_n) |-> brk_r >= $past(brk_r))
    else $error("break pointer moved backward");

  a_err_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_OK |-> out_addr_r == '0)
    else $error("error result carries an address");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_status_r <= ST_NO_BLOCK)
    else $error("status code out of range");

  a_commit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> !out_valid_r || out_ready)
    else $error("result overwrites an untaken word");

  for (genvar g = 0; g < NUM_BUCKETS; g++) begin : g_head_chk
    a_head_even: assert property (@(posedge clk) disable iff (!rst_n)
      head_r[g].valid |-> !head_r[g].offset[0])
      else $error("free list head at odd offset");
  end
`endif

endmodule

// File: design/pow2_bucket_block_allocator.sv
// A result word is registered by the evaluate step after acceptance, or by the write-back
// step after it for a free-list pop or a free that reaches the header memory (one read).
// One request at a time: none is accepted until the last result word is loaded (out_free).
// Reset (rst_n, synchronous, active low) starts a header memory clearing pass over all
// header entries; no request is accepted until it ends. Config writes always taken.
// Top level: APB config registers, stream packing; uses pbba_pkg, pbba_ctrl, pbba_dp.
module pow2_bucket_block_allocator
  import pbba_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] req_size, [31:16] block_addr
  input  logic        in_tuser,   // [0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [15:0] result_addr, [18:16] status, [23:19] zero
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic REG_HEAP_START = 1'b0;
  localparam logic REG_HEAP_LIMIT = 1'b1;

  logic [ADDR_W-1:0] heap_start_r;
  logic [ADDR_W-1:0] heap_limit_r;
  logic              cfg_wr;
  cmd_t              cmd;
  sts_t              sts;
  logic [ADDR_W-1:0] res_addr;
  logic [STAT_W-1:0] res_status;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_start_r <= '0;
      heap_limit_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_HEAP_START: heap_start_r <= cfg_pwdata[ADDR_W-1:0];
        REG_HEAP_LIMIT: heap_limit_r <= cfg_pwdata[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_HEAP_START: cfg_prdata = {16'b0, heap_start_r};
      REG_HEAP_LIMIT: cfg_prdata = {16'b0, heap_limit_r};
      default:        cfg_prdata = '0;
    endcase
  end

  pbba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pbba_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .heap_start      (heap_start_r),
    .heap_limit      (heap_limit_r),
    .in_req_type     (in_tuser),
    .in_req_size     (in_tdata[15:0]),
    .in_block_addr   (in_tdata[31:16]),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_result_addr (res_addr),
    .out_status      (res_status)
  );

  assign out_tdata = {5'b0, res_status, res_addr};

endmodule

// File: verif/tb_pow2_bucket_block_allocator.sv
// Self-checking testbench for pow2_bucket_block_allocator: directed and random
// allocate/free requests checked against an in-bench allocator predictor.
// Depends on design/pbba_pkg.sv and design/pow2_bucket_block_allocator.sv.
`timescale 1ns / 100ps

module tb_pow2_bucket_block_allocator;
  import pbba_pkg::*;

  localparam int unsigned REG_HEAP_START = 0;
  localparam int unsigned REG_HEAP_LIMIT = 1;
  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned LONG_HOLD      = 400;

  typedef struct {
    logic        kind;
    logic [15:0] size;
    logic [15:0] addr;
  } alloc_req_t;

  typedef struct {
    logic [15:0] addr;
    logic [2:0]  status;
  } alloc_reply_t;

  typedef struct {
    bit        exists;
    bit        in_use;
    bit [2:0]  bkt;
    bit        next_valid;
    bit [15:0] next;
  } blk_hdr_t;

  typedef struct {
    bit        valid;
    bit [15:0] offset;
  } list_head_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  pow2_bucket_block_allocator dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // allocator shadow state
  logic [15:0]  heap_start_q = '0;
  logic [15:0]  heap_limit_q = '0;
  logic [15:0]  brk_off = '0;
  list_head_t   free_head [NUM_BUCKETS];
  blk_hdr_t     blk_hdr [HEAP_GRANULES];

  alloc_req_t   request_fifo [$];
  alloc_reply_t pending_replies [$];
  logic [15:0]  live_addrs [$];
  logic [15:0]  freed_addrs [$];

  alloc_req_t   cur_req;
  int unsigned  n_issued = 0;
  int unsigned  n_offered = 0;
  int unsigned  n_accepted = 0;
  int unsigned  replies_seen = 0;
  int unsigned  err_count = 0;
  int unsigned  cycles = 0;
  int unsigned  burst_left = 0;
  int unsigned  gap_left = 0;
  int unsigned  hold_left = 0;
  bit           hold_done = 1'b0;
  int unsigned  stall_mode = 0;
  int unsigned  mode_left = 0;

  initial forever #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    err_count++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  function automatic alloc_reply_t predict_reply(alloc_req_t r);
    alloc_reply_t rep;
    int unsigned  cap;
    int unsigned  bkt;
    int unsigned  foot;
    int unsigned  new_brk;
    int unsigned  idx;
    logic [15:0]  off;
    rep.addr   = '0;
    rep.status = ST_OK;
    if (r.kind == REQ_ALLOC) begin
      cap = SMALLEST_CAPACITY;
      bkt = 0;
      while (bkt < NUM_BUCKETS && r.size > cap) begin
        cap = cap * 2;
        bkt++;
      end
      if (bkt >= NUM_BUCKETS) begin
        rep.status = ST_TOO_BIG;
      end else if (free_head[bkt].valid) begin
        off = free_head[bkt].offset;
        idx = 32'(off) >> 1;
        blk_hdr[idx].in_use      = 1'b1;
        free_head[bkt].valid     = blk_hdr[idx].next_valid;
        free_head[bkt].offset    = blk_hdr[idx].next;
        blk_hdr[idx].next_valid  = 1'b0;
        blk_hdr[idx].next        = '0;
        rep.addr = heap_start_q + off + 16'(HEADER_BYTES);
        live_addrs.push_back(rep.addr);
      end else begin
        foot = cap + HEADER_BYTES;
        foot = foot + (foot & 1);
        new_brk = 32'(brk_off) + foot;
        if (32'(heap_start_q) + new_brk > 32'(heap_limit_q) ||
            new_brk > 2 * HEAP_GRANULES) begin
          rep.status = ST_OOM;
        end else begin
          off = brk_off;
          idx = 32'(off) >> 1;
          blk_hdr[idx].exists     = 1'b1;
          blk_hdr[idx].in_use     = 1'b1;
          blk_hdr[idx].bkt        = 3'(bkt);
          blk_hdr[idx].next_valid = 1'b0;
          blk_hdr[idx].next       = '0;
          brk_off = 16'(new_brk);
          rep.addr = heap_start_q + off + 16'(HEADER_BYTES);
          live_addrs.push_back(rep.addr);
        end
      end
    end else if (r.addr != 0) begin
      off = r.addr - 16'(HEADER_BYTES) - heap_start_q;
      idx = 32'(off) >> 1;
      if (off[0] || idx >= HEAP_GRANULES) begin
        rep.status = ST_NO_BLOCK;
      end else if (!blk_hdr[idx].exists) begin
        rep.status = ST_NO_BLOCK;
      end else if (!blk_hdr[idx].in_use) begin
        rep.status = ST_DOUBLE_FREE;
      end else begin
        bkt = 32'(blk_hdr[idx].bkt);
        blk_hdr[idx].in_use     = 1'b0;
        blk_hdr[idx].next_valid = free_head[bkt].valid;
        blk_hdr[idx].next       = free_head[bkt].offset;
        free_head[bkt].valid    = 1'b1;
        free_head[bkt].offset   = off;
      end
    end
    return rep;
  endfunction

  // request side: predict on every accepted word
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      pending_replies.push_back(predict_reply(cur_req));
      n_accepted++;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!(in_tvalid && n_accepted != n_offered)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (request_fifo.size() > 0) begin
        cur_req = request_fifo.pop_front();
        n_offered++;
        in_tvalid <= 1'b1;
        in_tdata  <= {cur_req.addr, cur_req.size};
        in_tuser  <= cur_req.kind;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom % 4 == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // reply side
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (!hold_done && replies_seen >= 120) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom % 3;
        mode_left  = $urandom_range(16, 96);
      end
      mode_left--;
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom % 2);
        default: out_tready <= ($urandom % 4 == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    alloc_reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      replies_seen++;
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("unexpected word addr=%h status=%0d",
                                  out_tdata[15:0], out_tdata[18:16]));
      end else begin
        want = pending_replies.pop_front();
        if (out_tdata[15:0] !== want.addr)
          report_mismatch($sformatf("word %0d result_addr %h, want %h",
                                    replies_seen, out_tdata[15:0], want.addr));
        if (out_tdata[18:16] !== want.status)
          report_mismatch($sformatf("word %0d status %0d, want %0d",
                                    replies_seen, out_tdata[18:16], want.status));
      end
    end
  end

  task automatic cfg_write(int unsigned reg_idx, logic [15:0] value);
    logic [15:0] delta;
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 3'(reg_idx * 4);
    cfg_pwdata  <= {16'h0, value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (reg_idx == REG_HEAP_START) begin
      // keep the address pools pointing at the same blocks
      delta = value - heap_start_q;
      foreach (live_addrs[i]) live_addrs[i] = live_addrs[i] + delta;
      foreach (freed_addrs[i]) freed_addrs[i] = freed_addrs[i] + delta;
      heap_start_q = value;
    end else begin
      heap_limit_q = value;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic wait_idle();
    while (n_accepted != n_issued || pending_replies.size() != 0) @(negedge clk);
  endtask

  task automatic issue(logic kind, logic [15:0] size, logic [15:0] addr);
    alloc_req_t r;
    r.kind = kind;
    r.size = size;
    r.addr = addr;
    request_fifo.push_back(r);
    n_issued++;
  endtask

  task automatic issue_alloc(logic [15:0] size);
    issue(REQ_ALLOC, size, 16'($urandom));
  endtask

  task automatic issue_free(logic [15:0] addr);
    foreach (live_addrs[i]) begin
      if (live_addrs[i] == addr) begin
        live_addrs.delete(i);
        break;
      end
    end
    freed_addrs.push_back(addr);
    if (freed_addrs.size() > 64) void'(freed_addrs.pop_front());
    issue(REQ_FREE, 16'($urandom), addr);
  endtask

  function automatic logic [15:0] random_size();
    int unsigned r;
    int unsigned k;
    r = $urandom % 100;
    k = $urandom_range(0, NUM_BUCKETS - 1);
    if (r < 45) return 16'($urandom_range(0, 16));
    if (r < 70) return 16'($urandom_range(17, 128));
    if (r < 85) return 16'($urandom_range(129, 1024));
    if (r < 92) return 16'((SMALLEST_CAPACITY << k) + ($urandom % 2));
    return 16'($urandom_range(1025, 65535));
  endfunction

  task automatic issue_random();
    int unsigned r;
    int unsigned alloc_pct;
    logic [15:0] a;
    alloc_pct = (live_addrs.size() > 40) ? 35 : 55;
    if ($urandom % 100 < alloc_pct) begin
      issue_alloc(random_size());
    end else begin
      r = $urandom % 100;
      if (r < 55 && live_addrs.size() > 0) begin
        a = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
      end else if (r < 70 && freed_addrs.size() > 0) begin
        a = freed_addrs[$urandom_range(0, freed_addrs.size() - 1)];
      end else if (r < 78) begin
        a = '0;
      end else if (r < 90 && live_addrs.size() > 0) begin
        a = live_addrs[$urandom_range(0, live_addrs.size() - 1)] + 16'($urandom_range(1, 3));
      end else begin
        a = 16'($urandom);
      end
      issue_free(a);
    end
  endtask

  task automatic run_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      while (request_fifo.size() >= 4) @(negedge clk);
      issue_random();
    end
  endtask

  initial begin
    logic [15:0] x;
    logic [15:0] y;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // registers at reset: nothing can be allocated
    issue_alloc(16'd0);
    issue_free(16'd0);
    issue_free(16'd6);
    wait_idle();

    cfg_write(REG_HEAP_START, 16'h0000);
    cfg_write(REG_HEAP_LIMIT, 16'hFFFF);
    issue_alloc(16'd0);
    issue_alloc(16'd8);
    issue_alloc(16'd9);
    issue_alloc(16'd1024);
    issue_alloc(16'd1025);
    issue_alloc(16'hFFFF);
    wait_idle();
    x = live_addrs[0];
    y = live_addrs[1];
    issue_free(x);
    issue_free(x);
    issue_free(x + 16'd1);
    issue_free(16'hFFFF);
    issue_free(x + 16'd2);
    issue_free(16'd0);
    issue_free(y);
    issue_alloc(16'd1);
    issue_alloc(16'd2);
    issue_alloc(16'd16);
    wait_idle();

    // small heap: break runs out early, lists do the work
    cfg_write(REG_HEAP_START, 16'h0200);
    cfg_write(REG_HEAP_LIMIT, 16'h1A00);
    run_random(250);
    wait_idle();

    // top start address: only list pops succeed, addresses wrap
    cfg_write(REG_HEAP_START, 16'hFFFF);
    cfg_write(REG_HEAP_LIMIT, 16'hFFFF);
    run_random(100);
    wait_idle();

    cfg_write(REG_HEAP_START, 16'h1000);
    cfg_write(REG_HEAP_LIMIT, 16'hFFFF);
    run_random(150);
    wait_idle();
    run_random(150);
    wait_idle();

    cfg_write(REG_HEAP_START, 16'h0000);
    cfg_write(REG_HEAP_LIMIT, 16'h0000);
    run_random(100);
    wait_idle();

    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sim.f
design/pbba_pkg.sv
design/pbba_ctrl.sv
design/pbba_dp.sv
design/pow2_bucket_block_allocator.sv
verif/tb_pow2_bucket_block_allocator.sv
